// ===== hdl/universal_string_hash_bucket_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the string hash bucket unit
// Clocked implication checks with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef UNIVERSAL_STRING_HASH_BUCKET_UNIT_ASSERT_SVH
`define UNIVERSAL_STRING_HASH_BUCKET_UNIT_ASSERT_SVH

// Same-cycle implication
`define USHB_ASSERT_IMPLY(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define USHB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/ushb_pkg.sv =====
// ----------------------------------------------------------------------------
// ushb_pkg
// Types, codes and sizes shared by the string hash bucket unit and its
// channel interfaces.
// ----------------------------------------------------------------------------
package ushb_pkg;

  localparam int unsigned MAX_CHARS_DEF = 32;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COEF_W   = 64;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned BUCKET_W = 32;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [31:0] SLOT_COUNT_RESET = 32'd524288;

  // Register index, taken from byte address bit 2
  localparam logic REG_SLOT_COUNT = 1'b0;

  // One restoring step per bit of the 64-bit total
  localparam int unsigned DIV_STEPS = COEF_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_CHAR   = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_TOTAL,
    ST_DIV,
    ST_EMIT
  } state_e;

endpackage

// ===== hdl/ushb_if.sv =====
// ----------------------------------------------------------------------------
// ushb channel interfaces
// Valid/ready channels for command items and bucket result items.
// ----------------------------------------------------------------------------
interface ushb_in_if
  import ushb_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [INDEX_W-1:0]         coef_index;
  logic [COEF_W-1:0]          coef_value;
  logic signed [CHAR_W-1:0]   char_code;

  modport source (output valid, opcode, coef_index, coef_value, char_code, input ready);
  modport sink   (input valid, opcode, coef_index, coef_value, char_code, output ready);
endinterface

interface ushb_out_if
  import ushb_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] bucket;
  logic                too_long;

  modport source (output valid, bucket, too_long, input ready);
  modport sink   (input valid, bucket, too_long, output ready);
endinterface

// ===== hdl/universal_string_hash_bucket_unit.sv =====
// ----------------------------------------------------------------------------
// universal_string_hash_bucket_unit
// Load item: table write if in range. Char item: table read, 8x64 multiply,
// then accumulate on the shared 64-bit adder. Finish item: add of
// coefficient 0, then 64 restoring steps of the modulo on the same adder,
// to a registered result. Not ready while an item is in work; a waiting
// result only stalls the next finish. Reset (async, active low) clears the
// string state and sets slot_count to 524288; the table is not cleared.
// ----------------------------------------------------------------------------
`include "universal_string_hash_bucket_unit_assert.svh"

module universal_string_hash_bucket_unit
  import ushb_pkg::*;
#(
  parameter int unsigned MAX_CHARS = MAX_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ushb_in_if.sink               in_i,
  ushb_out_if.source            out_o,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [CFG_DATA_W-1:0] pwdata_i,
  output logic [CFG_DATA_W-1:0] prdata_o,
  output logic                  pready_o
);

  localparam int unsigned DEPTH  = MAX_CHARS + 1;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]        pos_q, pos_d;
  logic                     ovf_q, ovf_d;
  logic [COEF_W-1:0]        sum_q, sum_d;
  logic signed [CHAR_W-1:0] char_q, char_d;
  logic [COEF_W-1:0]        prod_q, prod_d;
  logic [COEF_W-1:0]        rdata_q;
  logic [COEF_W-1:0]        div_q, div_d;
  logic [BUCKET_W-1:0]      rem_q, rem_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic                     flag_q, flag_d;
  logic                     out_valid_q, out_valid_d;
  logic [BUCKET_W-1:0]      bucket_q, bucket_d;
  logic                     too_long_q, too_long_d;
  logic [BUCKET_W-1:0]      slot_q;

  logic [COEF_W-1:0] coef_mem [DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;
  logic              out_load;

  logic [COEF_W-1:0]         add_a, add_b;
  logic                      add_cin;
  logic [COEF_W:0]           add_res;
  logic [BUCKET_W:0]         shifted;
  logic signed [COEF_W+8:0]  full_prod;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Configuration port
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_SLOT_COUNT) ? slot_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= SLOT_COUNT_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 paddr_i[2] == REG_SLOT_COUNT) begin
      slot_q <= pwdata_i;
    end
  end

  // Coefficient table
  assign rd_addr = (in_i.opcode == OP_FINISH) ? '0 : ADDR_W'(pos_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (accept && in_i.opcode == OP_LOAD &&
        32'(in_i.coef_index) <= 32'(MAX_CHARS)) begin
      coef_mem[ADDR_W'(in_i.coef_index)] <= in_i.coef_value;
    end
    rdata_q <= coef_mem[rd_addr];
  end

  // Multiply by the sign-extended character
  assign full_prod = $signed(char_q) * $signed({1'b0, rdata_q});

  // Shared adder: accumulate, total, and the modulo's trial subtract
  assign shifted = {rem_q, div_q[COEF_W-1]};

  always_comb begin
    add_a   = sum_q;
    add_b   = prod_q;
    add_cin = 1'b0;
    case (state_q)
      ST_TOTAL: begin
        add_a = rdata_q;
        add_b = sum_q;
      end
      ST_DIV: begin
        add_a   = COEF_W'(shifted);
        add_b   = ~COEF_W'(slot_q);
        add_cin = 1'b1;
      end
      default: ;
    endcase
  end

  assign add_res = {1'b0, add_a} + {1'b0, add_b} + (COEF_W + 1)'(add_cin);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    ovf_d       = ovf_q;
    sum_d       = sum_q;
    char_d      = char_q;
    prod_d      = prod_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    flag_d      = flag_q;
    bucket_d    = bucket_q;
    too_long_d  = too_long_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_i.opcode)
            OP_CHAR: begin
              if (32'(pos_q) >= 32'(MAX_CHARS)) begin
                ovf_d = 1'b1;
              end else begin
                char_d  = in_i.char_code;
                pos_d   = ADDR_W'(pos_q + 1'b1);
                state_d = ST_MUL;
              end
            end
            OP_FINISH: begin
              flag_d  = ovf_q;
              pos_d   = '0;
              ovf_d   = 1'b0;
              state_d = ST_TOTAL;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        prod_d  = full_prod[COEF_W-1:0];
        state_d = ST_ACC;
      end
      ST_ACC: begin
        sum_d   = add_res[COEF_W-1:0];
        state_d = ST_IDLE;
      end
      ST_TOTAL: begin
        div_d   = add_res[COEF_W-1:0];
        sum_d   = '0;
        rem_d   = '0;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_d  = {div_q[COEF_W-2:0], 1'b0};
        // keep the difference when the trial subtract does not borrow
        rem_d  = add_res[COEF_W] ? add_res[BUCKET_W-1:0] : shifted[BUCKET_W-1:0];
        step_d = STEP_W'(step_q + 1'b1);
        if (step_q == LAST_STEP) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          bucket_d    = (slot_q == '0) ? '0 : rem_q;
          too_long_d  = flag_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      ovf_q       <= 1'b0;
      sum_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      ovf_q       <= ovf_d;
      sum_q       <= sum_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    prod_q     <= prod_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    flag_q     <= flag_d;
    bucket_q   <= bucket_d;
    too_long_q <= too_long_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.bucket   = bucket_q;
  assign out_o.too_long = too_long_q;

  // Checks
  `USHB_ASSERT_IMPLY(a_ovf_at_limit, clk_i, rst_ni, ovf_q, 32'(pos_q) == 32'(MAX_CHARS), "overflow flag set below the character limit")
  `USHB_ASSERT_NEXT(a_div_step, clk_i, rst_ni, state_q == ST_DIV && step_q != LAST_STEP, step_q == STEP_W'($past(step_q) + 1'b1), "modulo step counter skipped")
  `USHB_ASSERT_NEXT(a_emit_load, clk_i, rst_ni, out_load, out_valid_q && state_q == ST_IDLE, "result load did not take effect")
  `USHB_ASSERT_IMPLY(a_bucket_range, clk_i, rst_ni, out_valid_q && slot_q != '0, bucket_q < slot_q, "bucket not below slot count")

endmodule
